FILE: hw/rtl/brp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brp_pkg
// Shared types and constants of the blacklist remap picker.
// ----------------------------------------------------------------------------
package brp_pkg;

   localparam int MAX_VALUE   = 1024;
   localparam int MAX_ENTRIES = 256;
   localparam int VALUE_W     = 10;
   localparam int COUNT_W     = 9;
   localparam int INDEX_W     = 8;
   localparam int N_W         = 11;
   localparam int WORD_W      = 31;
   localparam int STEP_W      = 5;

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_FINISH = 2'd1,
      KIND_PICK   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_REJECT    = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_BUILT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      RES_OK,
      RES_REJECT,
      RES_FINISH,
      RES_EMPTY,
      RES_NOT_BUILT,
      RES_PICK
   } res_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_CHK,
      ST_CLR_RD,
      ST_CLR_WR,
      ST_FIN_INIT,
      ST_FIN_RD,
      ST_FIN_CHK,
      ST_FIN_SCAN,
      ST_PICK_CHK,
      ST_DIV,
      ST_PICK_RD,
      ST_PICK_SEL,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic    capture;
      logic    sweep_wr;
      logic    add_rd;
      logic    add_commit;
      logic    idx_clear;
      logic    list_rd;
      logic    unmark;
      logic    set_empty;
      logic    fin_init;
      logic    scan_rd;
      logic    next_inc;
      logic    map_wr;
      logic    idx_inc;
      logic    fin_done;
      logic    div_start;
      logic    div_step;
      logic    pick_rd;
      logic    res_set;
      res_type res;
      logic    out_load;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic add_reject;
      logic list_done;
      logic e_lt_bound;
      logic next_lt_n;
      logic bit_q;
      logic div_last;
      logic map_ready;
      logic bound_zero;
      logic out_free;
   } stat_type;

endpackage

FILE: hw/rtl/brp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brp_div
// Restoring remainder unit, one dividend bit per cycle while step is high.
// ----------------------------------------------------------------------------
module brp_div (
   input  logic                        clock,
   input  logic                        start,
   input  logic                        step,
   input  logic [brp_pkg::WORD_W-1:0]  dividend,
   input  logic [brp_pkg::N_W-1:0]     divisor,
   output logic                        last,
   output logic [brp_pkg::N_W-1:0]     rem
);
   import brp_pkg::*;

   logic [WORD_W-1:0] word_ff, word_in;
   logic [N_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [N_W:0]      trial;

   assign trial = {rem_ff, word_ff[WORD_W-1]};

   always_comb begin
      word_in = word_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         word_in = dividend;
         rem_in  = '0;
         cnt_in  = '0;
      end else if (step) begin
         word_in = {word_ff[WORD_W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = N_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[N_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

   assign last = (cnt_ff == STEP_W'(WORD_W - 1));
   assign rem  = rem_ff;

endmodule

FILE: hw/rtl/brp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brp_dp
// Datapath: excluded bitmap, entry list, remap table, divider, result word.
// ----------------------------------------------------------------------------
module brp_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  brp_pkg::cmd_type             cmd,
   output brp_pkg::stat_type            stat,
   input  logic                         csr_wr,
   input  logic [brp_pkg::N_W-1:0]      csr_data,
   input  logic [brp_pkg::VALUE_W-1:0]  req_entry_number,
   input  logic [brp_pkg::WORD_W-1:0]   req_random_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [brp_pkg::VALUE_W-1:0]  rsp_picked,
   output logic [1:0]                   rsp_status
);
   import brp_pkg::*;

   logic              bitmap_mem [MAX_VALUE];
   logic [VALUE_W-1:0] list_mem  [MAX_ENTRIES];
   logic [VALUE_W-1:0] remap_mem [MAX_VALUE];

   logic [N_W-1:0]     n_ff, n_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [N_W-1:0]     bound_ff, bound_in;
   logic               ready_ff, ready_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [N_W-1:0]     next_ff, next_in;
   logic [VALUE_W-1:0] sweep_ff, sweep_in;
   logic [VALUE_W-1:0] entry_ff;
   logic [WORD_W-1:0]  word_ff;
   logic               bit_q_ff;
   logic [VALUE_W-1:0] list_q_ff;
   logic [VALUE_W-1:0] remap_q_ff;
   logic [VALUE_W-1:0] res_picked_ff;
   status_type         res_status_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_picked_ff;
   logic [1:0]         rsp_status_ff;

   logic [N_W-1:0]     eff_n;
   logic [N_W-1:0]     rem;
   logic               div_last;
   logic [VALUE_W-1:0] rd_addr;
   logic               bm_we;
   logic [VALUE_W-1:0] bm_waddr;
   logic               bm_wdata;

   assign eff_n = (n_ff > N_W'(MAX_VALUE)) ? N_W'(MAX_VALUE) : n_ff;

   brp_div u_div (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (word_ff),
      .divisor  (bound_ff),
      .last     (div_last),
      .rem      (rem)
   );

   always_comb begin
      n_in     = n_ff;
      count_in = count_ff;
      bound_in = bound_ff;
      ready_in = ready_ff;
      idx_in   = idx_ff;
      next_in  = next_ff;
      sweep_in = sweep_ff;
      if (csr_wr) begin
         n_in = csr_data;
      end
      if (cmd.sweep_wr) begin
         sweep_in = sweep_ff + 1'b1;
      end
      if (cmd.add_commit) begin
         count_in = count_ff + 1'b1;
         ready_in = 1'b0;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end
      if (cmd.unmark || cmd.idx_inc || cmd.map_wr) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.set_empty) begin
         count_in = '0;
         bound_in = '0;
         ready_in = 1'b0;
      end
      if (cmd.fin_init) begin
         bound_in = (eff_n > N_W'(count_ff)) ? N_W'(eff_n - N_W'(count_ff)) : '0;
         next_in  = bound_in;
         idx_in   = '0;
      end
      if (cmd.next_inc || cmd.map_wr) begin
         next_in = next_ff + 1'b1;
      end
      if (cmd.fin_done) begin
         ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= N_W'(MAX_VALUE);
         count_ff <= '0;
         bound_ff <= '0;
         ready_ff <= 1'b0;
         sweep_ff <= '0;
      end else begin
         n_ff     <= n_in;
         count_ff <= count_in;
         bound_ff <= bound_in;
         ready_ff <= ready_in;
         sweep_ff <= sweep_in;
      end
      idx_ff  <= idx_in;
      next_ff <= next_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         entry_ff <= req_entry_number;
         word_ff  <= req_random_word;
      end
   end

   always_comb begin
      rd_addr = entry_ff;
      if (cmd.scan_rd) begin
         rd_addr = next_ff[VALUE_W-1:0];
      end else if (cmd.pick_rd) begin
         rd_addr = rem[VALUE_W-1:0];
      end
      bm_we    = cmd.sweep_wr || cmd.add_commit || cmd.unmark;
      bm_waddr = list_q_ff;
      bm_wdata = 1'b0;
      if (cmd.sweep_wr) begin
         bm_waddr = sweep_ff;
      end else if (cmd.add_commit) begin
         bm_waddr = entry_ff;
         bm_wdata = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (bm_we) begin
         bitmap_mem[bm_waddr] <= bm_wdata;
      end
      if (cmd.add_rd || cmd.scan_rd || cmd.pick_rd) begin
         bit_q_ff <= bitmap_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_commit) begin
         list_mem[count_ff[INDEX_W-1:0]] <= entry_ff;
      end
      if (cmd.list_rd) begin
         list_q_ff <= list_mem[idx_ff[INDEX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.map_wr) begin
         remap_mem[list_q_ff] <= next_ff[VALUE_W-1:0];
      end
      if (cmd.pick_rd) begin
         remap_q_ff <= remap_mem[rem[VALUE_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_picked_ff <= '0;
         case (cmd.res)
            RES_OK:        res_status_ff <= STATUS_OK;
            RES_REJECT:    res_status_ff <= STATUS_REJECT;
            RES_FINISH:    res_status_ff <= (bound_ff == '0) ? STATUS_EMPTY : STATUS_OK;
            RES_EMPTY:     res_status_ff <= STATUS_EMPTY;
            RES_NOT_BUILT: res_status_ff <= STATUS_NOT_BUILT;
            RES_PICK: begin
               res_status_ff <= STATUS_OK;
               res_picked_ff <= bit_q_ff ? remap_q_ff : rem[VALUE_W-1:0];
            end
            default:       res_status_ff <= STATUS_OK;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         rsp_picked_ff <= res_picked_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_picked = rsp_picked_ff;
   assign rsp_status = rsp_status_ff;

   assign stat.sweep_last = (sweep_ff == VALUE_W'(MAX_VALUE - 1));
   assign stat.add_reject = ({1'b0, entry_ff} >= eff_n) || bit_q_ff ||
                            (count_ff == COUNT_W'(MAX_ENTRIES));
   assign stat.list_done  = (idx_ff == count_ff);
   assign stat.e_lt_bound = ({1'b0, list_q_ff} < bound_ff);
   assign stat.next_lt_n  = (next_ff < eff_n);
   assign stat.bit_q      = bit_q_ff;
   assign stat.div_last   = div_last;
   assign stat.map_ready  = ready_ff;
   assign stat.bound_zero = (bound_ff == '0);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

endmodule

FILE: hw/rtl/brp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brp_ctrl
// Sequencer for add, finish, pick, clear, reset sweep and register writes.
// ----------------------------------------------------------------------------
module brp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [1:0]         req_kind,
   output logic               req_stall,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  brp_pkg::stat_type  stat,
   output brp_pkg::cmd_type   cmd
);
   import brp_pkg::*;

   state_type state_ff, state_in;
   logic      reply_ff, reply_in;
   logic      idle;
   logic      req_take;
   logic      csr_take;
   kind_type  kind;

   assign kind      = kind_type'(req_kind);
   assign idle      = (state_ff == ST_IDLE);
   assign csr_ready = idle;
   assign req_stall = !idle || csr_valid;
   assign csr_take  = idle && csr_valid;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      reply_in = reply_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (csr_take) begin
               reply_in = 1'b0;
               state_in = ST_CLR_RD;
            end else if (req_take) begin
               reply_in = 1'b1;
               unique case (kind)
                  KIND_ADD:    state_in = ST_ADD_RD;
                  KIND_FINISH: state_in = ST_FIN_INIT;
                  KIND_PICK:   state_in = ST_PICK_CHK;
                  KIND_CLEAR:  state_in = ST_CLR_RD;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD_RD:   state_in = ST_ADD_CHK;
         ST_ADD_CHK:  state_in = ST_RESULT;
         ST_CLR_RD: begin
            if (!stat.list_done) state_in = ST_CLR_WR;
            else if (reply_ff)   state_in = ST_RESULT;
            else                 state_in = ST_IDLE;
         end
         ST_CLR_WR:   state_in = ST_CLR_RD;
         ST_FIN_INIT: state_in = ST_FIN_RD;
         ST_FIN_RD: begin
            if (stat.list_done) state_in = ST_RESULT;
            else                state_in = ST_FIN_CHK;
         end
         ST_FIN_CHK: begin
            if (stat.e_lt_bound && stat.next_lt_n) state_in = ST_FIN_SCAN;
            else                                   state_in = ST_FIN_RD;
         end
         ST_FIN_SCAN: begin
            if (stat.bit_q) state_in = ST_FIN_CHK;
            else            state_in = ST_FIN_RD;
         end
         ST_PICK_CHK: begin
            if (!stat.map_ready || stat.bound_zero) state_in = ST_RESULT;
            else                                    state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_last) state_in = ST_PICK_RD;
         end
         ST_PICK_RD:  state_in = ST_PICK_SEL;
         ST_PICK_SEL: state_in = ST_RESULT;
         ST_RESULT: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd     = '0;
      cmd.res = RES_OK;
      unique case (state_ff)
         ST_SWEEP: cmd.sweep_wr = 1'b1;
         ST_IDLE: begin
            cmd.capture   = req_take;
            cmd.idx_clear = csr_take || (req_take && kind == KIND_CLEAR);
         end
         ST_ADD_RD: cmd.add_rd = 1'b1;
         ST_ADD_CHK: begin
            cmd.res_set    = 1'b1;
            cmd.add_commit = !stat.add_reject;
            cmd.res        = stat.add_reject ? RES_REJECT : RES_OK;
         end
         ST_CLR_RD: begin
            cmd.list_rd   = !stat.list_done;
            cmd.set_empty = stat.list_done;
            cmd.res_set   = stat.list_done;
            cmd.res       = RES_OK;
         end
         ST_CLR_WR:   cmd.unmark = 1'b1;
         ST_FIN_INIT: cmd.fin_init = 1'b1;
         ST_FIN_RD: begin
            cmd.list_rd  = !stat.list_done;
            cmd.fin_done = stat.list_done;
            cmd.res_set  = stat.list_done;
            cmd.res      = RES_FINISH;
         end
         ST_FIN_CHK: begin
            cmd.scan_rd = stat.e_lt_bound && stat.next_lt_n;
            cmd.idx_inc = !(stat.e_lt_bound && stat.next_lt_n);
         end
         ST_FIN_SCAN: begin
            cmd.next_inc = stat.bit_q;
            cmd.map_wr   = !stat.bit_q;
         end
         ST_PICK_CHK: begin
            cmd.res_set   = !stat.map_ready || stat.bound_zero;
            cmd.res       = !stat.map_ready ? RES_NOT_BUILT : RES_EMPTY;
            cmd.div_start = stat.map_ready && !stat.bound_zero;
         end
         ST_DIV:     cmd.div_step = 1'b1;
         ST_PICK_RD: cmd.pick_rd = 1'b1;
         ST_PICK_SEL: begin
            cmd.res_set = 1'b1;
            cmd.res     = RES_PICK;
         end
         ST_RESULT: cmd.out_load = stat.out_free;
         default:   cmd.res = RES_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         reply_ff <= reply_in;
      end
   end

endmodule

FILE: hw/rtl/blacklist_remap_picker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blacklist_remap_picker_top
// Uniform pick from 0 .. n-1 with a loaded set of numbers excluded.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command word (add, finish, pick, clear) under
//   valid/stall; rsp_* returns exactly one result word per command.
//   csr_* writes universe_size (n); a write empties the set and is taken
//   only while the block is idle.
// Steps (one command at a time, sequenced by the controller):
//   add     bitmap read, check, result
//   clear   entry list walk, one bitmap write each, then result
//   finish  list walk plus bitmap scan for the next free number
//   pick    31-step remainder unit, bitmap and remap read
// The result register decouples the sides: a new command is taken while the
// previous result still waits, and a stalled result is held unchanged.
// Reset runs a sweep that clears every bitmap entry; req_stall stays high
// and csr_ready low until it ends. A register write adds a clearing walk
// of the entry list.
// ----------------------------------------------------------------------------
module blacklist_remap_picker_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_kind,
   input  logic [brp_pkg::VALUE_W-1:0]  req_entry_number,
   input  logic [brp_pkg::WORD_W-1:0]   req_random_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [brp_pkg::VALUE_W-1:0]  rsp_picked,
   output logic [1:0]                   rsp_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [brp_pkg::N_W-1:0]      csr_data
);
   import brp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   brp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   brp_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr           (csr_valid && csr_ready),
      .csr_data         (csr_data),
      .req_entry_number (req_entry_number),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_picked       (rsp_picked),
      .rsp_status       (rsp_status)
   );

endmodule

FILE: hw/rtl/brp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brp_checker
// Port-level checks of the blacklist remap picker, bound to the top level.
// ----------------------------------------------------------------------------
module brp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [9:0] rsp_picked,
   input logic [1:0] rsp_status,
   input logic       csr_ready
);
   import brp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_picked) && $stable(rsp_status))
      else $error("stalled result word changed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_picked == '0)
      else $error("failed result word carries a nonzero pick");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !csr_ready && req_stall)
      else $error("block idle right after taking a command word");

   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> req_stall && !csr_ready)
      else $error("block open right after reset");

endmodule

bind blacklist_remap_picker_top brp_checker u_brp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_picked (rsp_picked),
   .rsp_status (rsp_status),
   .csr_ready  (csr_ready)
);
